[sv/assert_macros.svh]
//------------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, with or without rst as disable
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define AP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property checked at every edge, reset included
`define AP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/apft_pkg.sv]
//------------------------------------------------------------------------------
// apft_pkg
// shared types, codes and helpers of the address prefix filter table
//------------------------------------------------------------------------------
package apft_pkg;

  localparam int ADDR_BYTES        = 6;
  localparam int ADDR_W            = 8 * ADDR_BYTES;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int CFG_DATA_W        = 8;
  localparam int COUNT_OUT_W       = 5;

  typedef enum logic [1:0] {
    CMD_CHECK     = 2'd0,
    CMD_ADD_ALLOW = 2'd1,
    CMD_ADD_DENY  = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_TYPE_FILTER_MASK = 1'b0,
    REG_MAX_REPORT_LEN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] address;
    logic [2:0]        prefix_bytes;
    logic [7:0]        sender_type;
    logic [7:0]        report_len;
    logic [7:0]        signal_strength;
  } in_item_t;

  typedef struct packed {
    logic                   accept;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  // token walking down the cell row
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ADDR_W-1:0] address;
  } scan_t;

  // entry write strobe, broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] key;
    logic [2:0]        len;
  } entry_wr_t;

  // mask over the top len bytes of an address
  function automatic logic [ADDR_W-1:0] high_mask(input logic [2:0] len);
    logic [ADDR_W-1:0] m;
    case (len)
      3'd1:    m = 48'hFF00_0000_0000;
      3'd2:    m = 48'hFFFF_0000_0000;
      3'd3:    m = 48'hFFFF_FF00_0000;
      3'd4:    m = 48'hFFFF_FFFF_0000;
      3'd5:    m = 48'hFFFF_FFFF_FF00;
      default: m = 48'hFFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // move the low len entry bytes up to the top of the address
  function automatic logic [ADDR_W-1:0] align_key(input logic [ADDR_W-1:0] bytes,
                                                  input logic [2:0] len);
    logic [ADDR_W-1:0] k;
    case (len)
      3'd1:    k = {bytes[7:0],  40'h0};
      3'd2:    k = {bytes[15:0], 32'h0};
      3'd3:    k = {bytes[23:0], 24'h0};
      3'd4:    k = {bytes[31:0], 16'h0};
      3'd5:    k = {bytes[39:0], 8'h0};
      default: k = bytes;
    endcase
    return k;
  endfunction

endpackage

[sv/apft_cell.sv]
//------------------------------------------------------------------------------
// apft_cell
// one table slot: holds an aligned prefix and compares the passing token
//------------------------------------------------------------------------------
module apft_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CNT_W-1:0]   count,
  input  apft_pkg::entry_wr_t wr,
  input  apft_pkg::scan_t    scan_in,
  output apft_pkg::scan_t    scan_out
);
  import apft_pkg::*;

  logic [ADDR_W-1:0] key;
  logic [2:0]        len;
  logic              occupied;
  logic              match;

  assign occupied = CNT_W'(INDEX) < count;
  assign match    = occupied && ((scan_in.address & high_mask(len)) == key);

  // slot write lands on the first free slot
  always_ff @(posedge clk) begin
    if (wr.en && (count == CNT_W'(INDEX))) begin
      key <= wr.key;
      len <= wr.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    scan_out.hit     <= scan_in.hit | match;
    scan_out.address <= scan_in.address;
  end

endmodule

[sv/address_prefix_filter_table_core.sv]
//------------------------------------------------------------------------------
// address_prefix_filter_table_core
// report filter by sender address prefix, allow or deny list
//------------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall / in_item, one command per transfer
//   out channel: out_valid / out_stall / out_item, exactly one result per item
//   cfg port: cfg_write with cfg_index and cfg_data, written while idle
// result path
//   check: the input transfer launches a token that walks one cell per cycle
//   down the row of table slots; the result then goes to the pending register
//   and on to the output register; add / clear pass the pending and output registers
// flow
//   one item at a time; the next item is taken once the current one has
//   moved to the output register
// reset
//   table emptied, allow mode, type mask 0, length limit 229, no result held
// stall
//   a stalled result holds in the output register; one more finished result
//   waits in the pending register and in_stall stays high until it moves
//------------------------------------------------------------------------------
module address_prefix_filter_table_core #(
  parameter int TABLE_ENTRIES = apft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  apft_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output apft_pkg::out_item_t             out_item,
  input  logic                            cfg_write,
  input  apft_pkg::reg_idx_t              cfg_index,
  input  logic [apft_pkg::CFG_DATA_W-1:0] cfg_data
);
  import apft_pkg::*;

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PEND
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              deny_mode;
  logic [7:0]        type_filter_mask;
  logic [7:0]        max_report_len;
  logic              pre_ok;
  out_item_t         pend;
  scan_t             launch;
  scan_t             chain [0:TABLE_ENTRIES];
  entry_wr_t         wr;

  logic              in_xfer;
  logic              add_cmd;
  logic              add_ok;
  logic              table_full;
  logic              chk_ok;
  logic              match_final;
  logic              pend_move;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W+4:0]  count_ext;

  assign in_stall   = (state != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign add_cmd    = (in_item.command == CMD_ADD_ALLOW) || (in_item.command == CMD_ADD_DENY);
  // prefix length must be 1..6 or the add changes neither table nor mode
  assign add_ok     = add_cmd && (in_item.prefix_bytes != 3'd0) &&
                      (in_item.prefix_bytes <= 3'(ADDR_BYTES));
  assign table_full = !(count < CNT_W'(TABLE_ENTRIES));

  // length, type and signal strength checks, judged on entry
  assign chk_ok = (in_item.report_len != 8'd0) &&
                  (in_item.report_len <= max_report_len) &&
                  ((in_item.sender_type & type_filter_mask) == 8'd0) &&
                  (in_item.signal_strength != 8'd0);

  // entry write into the first free cell
  always_comb begin
    wr.en  = in_xfer && add_ok && !table_full;
    wr.key = align_key(in_item.address, in_item.prefix_bytes);
    wr.len = in_item.prefix_bytes;
  end

  always_comb begin
    count_next = count;
    case (in_item.command)
      CMD_CHECK:     count_next = count;
      CMD_ADD_ALLOW,
      CMD_ADD_DENY:  if (add_ok && !table_full) count_next = count + CNT_W'(1);
      CMD_CLEAR:     count_next = '0;
      default:       count_next = count;
    endcase
  end

  // empty table matches everything, deny mode inverts only a real lookup
  assign match_final = (count == '0) || (deny_mode ^ chain[TABLE_ENTRIES].hit);

  // output count is the low five bits of the slot count
  assign count_ext = {5'd0, count};

  // finished result moves to the output register when it is free or draining
  assign pend_move = (state == S_PEND) && (!out_valid || !out_stall);

  // row of slots, token enters at the head
  assign chain[0] = launch;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    apft_cell #(
      .INDEX(i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .wr      (wr),
      .scan_in (chain[i]),
      .scan_out(chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      deny_mode        <= 1'b0;
      type_filter_mask <= 8'd0;
      max_report_len   <= 8'd229;
      launch.valid     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TYPE_FILTER_MASK: type_filter_mask <= cfg_data;
          REG_MAX_REPORT_LEN:   max_report_len   <= cfg_data;
          default:              ;
        endcase
      end

      // token enters the row only for a check
      launch.valid <= in_xfer && (in_item.command == CMD_CHECK);

      if (pend_move) begin
        out_item  <= pend;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            count <= count_next;
            if (add_ok) begin
              deny_mode <= (in_item.command == CMD_ADD_DENY);
            end
            // token payload
            launch.hit     <= 1'b0;
            launch.address <= in_item.address;
            pre_ok         <= chk_ok;
            if (in_item.command == CMD_CHECK) begin
              state <= S_SCAN;
            end else begin
              pend.accept      <= 1'b0;
              pend.entry_count <= COUNT_OUT_W'(count_next);
              state            <= S_PEND;
            end
          end
        end
        S_SCAN: begin
          if (chain[TABLE_ENTRIES].valid) begin
            pend.accept      <= pre_ok && match_final;
            pend.entry_count <= count_ext[4:0];
            state            <= S_PEND;
          end
        end
        S_PEND: begin
          if (pend_move) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AP_ASSERT(a_busy_after_xfer, in_xfer |=> (state != S_IDLE), "input transfer left the core idle")

  `AP_ASSERT(a_tail_in_scan, chain[TABLE_ENTRIES].valid |-> (state == S_SCAN), "token left the row outside a scan")

  `AP_ASSERT(a_pend_moves, ((state == S_PEND) && !(out_valid && out_stall)) |=> out_valid, "pending result not moved to output")

  `AP_ASSERT(a_clear_empties, (in_xfer && (in_item.command == CMD_CLEAR)) |=> (count == '0), "clear did not empty the table")

  `AP_ASSERT(a_count_bound, count <= CNT_W'(TABLE_ENTRIES), "slot count above table size")

endmodule

[tb/tb.sv]
//------------------------------------------------------------------------------
// tb
// self-checking bench for address_prefix_filter_table_core: a directed run over
// the filter corner cases, then random sessions of clear / add / check traffic
// with random idling on both channels, predicted by a local table model
//------------------------------------------------------------------------------
module tb;
  import apft_pkg::*;

  localparam int TABLE_SLOTS    = TABLE_ENTRIES_DEF;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_write = 1'b0;
  reg_idx_t  cfg_index = REG_TYPE_FILTER_MASK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  address_prefix_filter_table_core #(
    .TABLE_ENTRIES(TABLE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // local copy of the filter state
  logic [ADDR_W-1:0] tbl_key [TABLE_SLOTS];
  logic [2:0]        tbl_len [TABLE_SLOTS];
  int                tbl_used = 0;
  logic              tbl_deny = 1'b0;
  logic [7:0]        flt_type_mask = 8'd0;
  logic [7:0]        flt_max_len = 8'd229;

  in_item_t  cmd_backlog[$];     // items waiting to be offered
  out_item_t verdict_queue[$];   // predicted results, oldest first
  int        fail_count = 0;
  logic      steady_flow = 1'b0; // no random idling on either side while set
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      rx_stall_rand = 1'b0;
  int        idle_cycles = 0;

  function automatic logic [63:0] low_bytes_mask(input int n);
    return (64'h1 << (8 * n)) - 64'h1;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one item through the filter, state updated, result returned
  function automatic out_item_t judge_report(input in_item_t it);
    out_item_t    res;
    logic         hit;
    logic [63:0]  m;
    int           n;
    int           i;
    res.accept = 1'b0;
    hit = 1'b0;
    case (it.command)
      CMD_CHECK: begin
        if (tbl_used == 0) begin
          hit = 1'b1;
        end else begin
          for (i = 0; i < tbl_used; i++) begin
            n = int'(tbl_len[i]);
            m = low_bytes_mask(n);
            // prefix sits at the most significant end of the address
            if ((({16'h0, it.address} >> (8 * (ADDR_BYTES - n))) & m) ==
                ({16'h0, tbl_key[i]} & m))
              hit = 1'b1;
          end
          hit = hit ^ tbl_deny;
        end
        res.accept = (it.report_len != 8'd0) && (it.report_len <= flt_max_len) &&
                     ((it.sender_type & flt_type_mask) == 8'd0) &&
                     (it.signal_strength != 8'd0) && hit;
      end
      CMD_ADD_ALLOW, CMD_ADD_DENY: begin
        if (it.prefix_bytes >= 3'd1 && it.prefix_bytes <= 3'(ADDR_BYTES)) begin
          tbl_deny = (it.command == CMD_ADD_DENY);
          if (tbl_used < TABLE_SLOTS) begin
            m = low_bytes_mask(int'(it.prefix_bytes));
            tbl_key[tbl_used] = it.address & m[ADDR_W-1:0];
            tbl_len[tbl_used] = it.prefix_bytes;
            tbl_used++;
          end
        end
      end
      default: tbl_used = 0;
    endcase
    res.entry_count = tbl_used[COUNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic in_item_t mk_item(input cmd_t c, input logic [ADDR_W-1:0] a,
                                       input logic [2:0] n, input logic [7:0] ty,
                                       input logic [7:0] len, input logic [7:0] sig);
    in_item_t it;
    it.command         = c;
    it.address         = a;
    it.prefix_bytes    = n;
    it.sender_type     = ty;
    it.report_len      = len;
    it.signal_strength = sig;
    return it;
  endfunction

  // check with report fields mostly passing the current limits
  function automatic in_item_t mk_check(input logic [ADDR_W-1:0] a);
    logic [7:0] len;
    logic [7:0] ty;
    logic [7:0] sig;
    int         r;
    r = $urandom_range(0, 9);
    if (r == 0) len = 8'd0;
    else if (r == 1 || flt_max_len == 8'd0) len = 8'($urandom_range(0, 255));
    else if (r == 2) len = flt_max_len;
    else if (r == 3) len = flt_max_len + 8'd1;
    else len = 8'($urandom_range(1, flt_max_len));
    ty  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : (8'($urandom) & ~flt_type_mask);
    sig = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return mk_item(CMD_CHECK, a, 3'($urandom), ty, len, sig);
  endfunction

  // in channel driver: predicts at each input transfer, then offers the next item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && !in_stall)
        verdict_queue.push_back(judge_report(in_item));
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (cmd_backlog.size() != 0) begin
          in_item  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
          tx_gap   <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // out channel monitor and random stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      rx_stall_rand <= 1'b0;
      rx_gap        <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("error: result with nothing expected, accept=%0b count=%0d",
                     out_item.accept, out_item.entry_count);
        end else begin
          want = verdict_queue.pop_front();
          if (out_item.accept !== want.accept ||
              out_item.entry_count !== want.entry_count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("error: accept exp %0b got %0b, entry_count exp %0d got %0d",
                       want.accept, out_item.accept, want.entry_count,
                       out_item.entry_count);
          end
        end
      end
      if (rx_gap != 0) begin
        rx_stall_rand <= 1'b1;
        rx_gap        <= rx_gap - 1;
      end else begin
        rx_stall_rand <= 1'b0;
        if (!steady_flow && $urandom_range(0, 3) == 0)
          rx_gap <= pick_gap();
      end
    end
  end

  // long receiver hold-off, once, so the block backs up into in_stall
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_OFF_LEN;
      hold_done <= 1'b1;
    end
  end

  assign out_stall = rx_stall_rand | (hold_left != 0);

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TYPE_FILTER_MASK) flt_type_mask = val;
    else flt_max_len = val;
  endtask

  // all items offered and all results back
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_valid || verdict_queue.size() != 0)
      @(posedge clk);
    repeat (TABLE_SLOTS + 4) @(posedge clk);
  endtask

  // table session: optional clear, adds, checks mostly at new entries; or noise
  task automatic queue_filter_session(inout int queued);
    logic [ADDR_W-1:0] keys[$];
    int                lens[$];
    logic [ADDR_W-1:0] a;
    logic [63:0]       w;
    logic              sess_deny;
    cmd_t              c;
    int                n;
    int                k;
    int                r;
    int                j;
    int                nadd;
    int                nchk;
    if ($urandom_range(0, 7) == 0) begin
      // noise: anything the fields allow
      repeat (6) begin
        cmd_backlog.push_back(mk_item(cmd_t'($urandom_range(0, 3)), rand_addr(),
                                      3'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom)));
        queued++;
      end
      return;
    end
    if ($urandom_range(0, 3) != 0) begin
      cmd_backlog.push_back(mk_item(CMD_CLEAR, rand_addr(), 3'($urandom), 8'($urandom),
                                    8'($urandom), 8'($urandom)));
      queued++;
    end
    sess_deny = 1'($urandom_range(0, 1));
    nadd = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    for (j = 0; j < nadd; j++) begin
      r = $urandom_range(0, 19);
      n = (r == 0) ? 0 : (r == 1) ? 7 : $urandom_range(1, ADDR_BYTES);
      c = (sess_deny ^ ($urandom_range(0, 5) == 0)) ? CMD_ADD_DENY : CMD_ADD_ALLOW;
      a = rand_addr();
      cmd_backlog.push_back(mk_item(c, a, 3'(n), 8'($urandom), 8'($urandom),
                                    8'($urandom)));
      queued++;
      if (n >= 1 && n <= ADDR_BYTES) begin
        w = {16'h0, a} & low_bytes_mask(n);
        keys.push_back(w[ADDR_W-1:0]);
        lens.push_back(n);
      end
    end
    nchk = $urandom_range(4, 12);
    for (j = 0; j < nchk; j++) begin
      r = $urandom_range(0, 3);
      if (keys.size() != 0 && r != 0) begin
        k = $urandom_range(0, keys.size() - 1);
        n = lens[k];
        // entry bytes at the top, random tail below
        w = ({16'h0, keys[k]} << (8 * (ADDR_BYTES - n))) |
            ({16'h0, rand_addr()} & low_bytes_mask(ADDR_BYTES - n));
        a = w[ADDR_W-1:0];
        // near miss: one bit flipped inside the prefix
        if (r == 1)
          a = a ^ (48'h1 << (ADDR_W - 1 - $urandom_range(0, 8 * n - 1)));
      end else begin
        a = rand_addr();
      end
      cmd_backlog.push_back(mk_check(a));
      queued++;
    end
  endtask

  task automatic run_phase(input logic [7:0] mask, input logic [7:0] max_len,
                           input logic steady, input int count);
    int queued;
    queued = 0;
    write_reg(REG_TYPE_FILTER_MASK, mask);
    write_reg(REG_MAX_REPORT_LEN, max_len);
    steady_flow = steady;
    if (steady) hold_req <= 1'b1;
    while (queued < count)
      queue_filter_session(queued);
    wait_idle();
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings: empty table, allow mode
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hFFFF_FFFF_FFFF, 3'd0, 8'hFF, 8'd229, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h0, 3'd7, 8'h00, 8'd0, 8'hFF));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h0, 3'd0, 8'h00, 8'd230, 8'hFF));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h0, 3'd0, 8'h00, 8'd1, 8'd0));
    // bad add lengths, ignored
    cmd_backlog.push_back(mk_item(CMD_ADD_ALLOW, 48'h12, 3'd0, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_ADD_DENY, 48'h12, 3'd7, 8'h0, 8'd1, 8'd1));
    // one byte prefix, garbage above it must be dropped
    cmd_backlog.push_back(mk_item(CMD_ADD_ALLOW, 48'hFFFF_FFFF_FFAB, 3'd1, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hAB00_0000_0000, 3'd0, 8'h00, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hAA00_0000_0000, 3'd0, 8'h00, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_ADD_ALLOW, 48'hFFFF_FFFF_FFFF, 3'd6, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hFFFF_FFFF_FFFF, 3'd0, 8'h00, 8'd1, 8'd1));
    // deny add flips the whole list to deny
    cmd_backlog.push_back(mk_item(CMD_ADD_DENY, 48'h12_3456, 3'd3, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h1234_5600_0000, 3'd0, 8'h00, 8'd9, 8'd9));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h0, 3'd0, 8'h00, 8'd9, 8'd9));
    // clear keeps deny mode, empty table still matches everything
    cmd_backlog.push_back(mk_item(CMD_CLEAR, 48'h0, 3'd0, 8'h00, 8'd0, 8'd0));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h0, 3'd0, 8'h00, 8'd9, 8'd9));
    cmd_backlog.push_back(mk_item(CMD_ADD_DENY, 48'h0, 3'd2, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h0, 3'd0, 8'h00, 8'd9, 8'd9));
    cmd_backlog.push_back(mk_item(CMD_ADD_ALLOW, 48'h0000_DEAD_BEEF, 3'd4, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hDEAD_BEEF_0000, 3'd0, 8'h00, 8'd9, 8'd9));
    cmd_backlog.push_back(mk_item(CMD_ADD_DENY, 48'h0, 3'd7, 8'h0, 8'd1, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'h1111_1111_1111, 3'd0, 8'h00, 8'd9, 8'd9));
    wait_idle();

    // zero length limit rejects everything
    write_reg(REG_MAX_REPORT_LEN, 8'd0);
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hDEAD_BEEF_0000, 3'd0, 8'h00, 8'd1, 8'd1));
    wait_idle();
    // type mask against single bits
    write_reg(REG_TYPE_FILTER_MASK, 8'h01);
    write_reg(REG_MAX_REPORT_LEN, 8'd255);
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hDEAD_BEEF_0000, 3'd0, 8'h01, 8'd255, 8'd1));
    cmd_backlog.push_back(mk_item(CMD_CHECK, 48'hDEAD_BEEF_0000, 3'd0, 8'hFE, 8'd255, 8'd1));
    wait_idle();

    // random sessions over several settings; the steady one carries the hold-off
    run_phase(8'h00, 8'd255, 1'b0, 200);
    run_phase(8'hFF, 8'd1, 1'b0, 200);
    run_phase(8'h81, 8'd229, 1'b1, 200);
    run_phase(8'($urandom), 8'($urandom_range(1, 255)), 1'b0, 200);
    run_phase(8'h3C, 8'd128, 1'b0, 200);

    if (fail_count == 0 && verdict_queue.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
